### hdl/pcmt_pkg.sv
// ============================================================================
// pcmt_pkg: shared types and constants for the prefix command match table
// Table sizes, derived widths, result codes and the sequencer state type.
// ============================================================================
`timescale 1ns / 1ps

package pcmt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int MAX_KW_LEN  = 16;

    localparam int CHAR_W = 8;
    localparam int CODE_W = 16;

    // lane index into a character row, row index into the character memory
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int POS_W  = (MAX_KW_LEN > 1) ? $clog2(MAX_KW_LEN) : 1;
    // entry count up to MAX_ENTRIES, query position up to MAX_KW_LEN,
    // load position saturating at MAX_KW_LEN + 1
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W  = $clog2(MAX_KW_LEN + 1);
    localparam int LPOS_W = $clog2(MAX_KW_LEN + 2);
    localparam int ROW_W  = MAX_ENTRIES * CHAR_W;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] LOAD_STORED   = 2'd0;
    localparam logic [1:0] LOAD_FULL     = 2'd1;
    localparam logic [1:0] LOAD_TOO_LONG = 2'd2;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } hit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CODE
    } state_t;

endpackage

### hdl/pcmt_ram.sv
// ============================================================================
// pcmt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module pcmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/pcmt_match.sv
// ============================================================================
// pcmt_match: per-entry character compare and first-match select
// Compare one query character against a whole character row, drop entries
// that differ, and pick the earliest entry fully matched so far.
// ============================================================================
`timescale 1ns / 1ps

module pcmt_match
    import pcmt_pkg::*;
(
    input  row_t                   row,
    input  char_t                  char_val,
    input  logic [LEN_W-1:0]       qpos,
    input  logic [CNT_W-1:0]       count,
    input  len_t [MAX_ENTRIES-1:0] lens,
    input  logic [MAX_ENTRIES-1:0] alive,
    output logic [MAX_ENTRIES-1:0] alive_next,
    output hit_t                   hit
);

    logic             in_range;
    logic [LEN_W-1:0] qpos_next;
    logic [MAX_ENTRIES-1:0] cand;

    assign in_range  = qpos < LEN_W'(MAX_KW_LEN);
    assign qpos_next = in_range ? qpos + 1'b1 : qpos;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            alive_next[i] = alive[i];
            if (in_range && (CNT_W'(i) < count) && (qpos < lens[i]) &&
                (row[i*CHAR_W +: CHAR_W] != char_val))
            begin
                alive_next[i] = 1'b0;
            end
            cand[i] = alive_next[i] && (CNT_W'(i) < count) && (lens[i] <= qpos_next);
        end
    end

    // lowest index wins
    always_comb
    begin
        hit.found = |cand;
        hit.idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit.idx = IDX_W'(i);
            end
        end
    end

endmodule

### hdl/prefix_command_match_table.sv
// Sequencing: an accepted item goes to ST_EXEC, which finishes a load
// character or a non-final query character; a final load character waits
// there for a free output register to take its status, and a final query
// character goes on to ST_CODE for its code lookup and answer. Each item
// reads and may write back one character row; none is taken outside ST_IDLE.
// Reset: counters, positions and match mask clear at once; memories are not
// cleared and need no clearing pass, so items are taken right after reset.
// ============================================================================
// prefix_command_match_table: keyword table with prefix lookup
// Stores keywords with 16-bit codes and answers queries with the code of the
// earliest keyword that is a prefix of the query string.
// ============================================================================
`timescale 1ns / 1ps

module prefix_command_match_table
    import pcmt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_in, [23:8] code_in
    input  logic                   s_axis_tlast,   // last
    input  logic                   s_axis_tuser,   // mode

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] status, [2] found,
                                                   // [18:3] code_out, rest zero
    output logic                   m_axis_tuser    // result_kind
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic                   mode_reg, last_reg;
    char_t                  char_reg;
    logic [CODE_W-1:0]      code_reg;

    logic [CNT_W-1:0]       entry_count_reg, entry_count_next;
    logic [LPOS_W-1:0]      load_pos_reg, load_pos_next;
    logic                   load_ovf_reg, load_ovf_next;
    logic [LEN_W-1:0]       query_pos_reg, query_pos_next;
    logic [MAX_ENTRIES-1:0] alive_reg, alive_next;
    len_t [MAX_ENTRIES-1:0] len_reg, len_next;
    logic                   hit_found_reg, hit_found_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_found_reg, out_found_next;
    logic [CODE_W-1:0]      out_code_reg, out_code_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic                   row_rd_en, row_wr_en;
    logic [POS_W-1:0]       row_rd_addr;
    row_t                   row_rd_data, row_wr_data;
    logic                   code_rd_en, code_wr_en;
    logic [CODE_W-1:0]      code_rd_data;

    logic                   in_xfer;
    logic                   out_free;
    logic                   table_full;
    logic                   pos_in_range;
    logic                   ovf_eff;
    logic [LPOS_W-1:0]      lpos_inc;
    logic [MAX_ENTRIES-1:0] match_alive;
    hit_t                   hit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Read the character row at the string position of the incoming item.
    assign row_rd_en   = in_xfer;
    assign row_rd_addr = (s_axis_tuser == MODE_QUERY) ? query_pos_reg[POS_W-1:0]
                                                      : load_pos_reg[POS_W-1:0];

    // Load bookkeeping
    assign table_full   = entry_count_reg >= CNT_W'(MAX_ENTRIES);
    assign pos_in_range = load_pos_reg < LPOS_W'(MAX_KW_LEN);
    assign ovf_eff      = load_ovf_reg || !pos_in_range;
    assign lpos_inc     = (load_pos_reg <= LPOS_W'(MAX_KW_LEN)) ? load_pos_reg + 1'b1
                                                                 : load_pos_reg;

    // Replace this entry's lane in the row, keep the others.
    always_comb
    begin
        row_wr_data = row_rd_data;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (entry_count_reg[IDX_W-1:0] == IDX_W'(i))
            begin
                row_wr_data[i*CHAR_W +: CHAR_W] = char_reg;
            end
        end
    end

    assign row_wr_en  = (state_reg == ST_EXEC) && (mode_reg == MODE_LOAD) &&
                        !table_full && pos_in_range && (!last_reg || out_free);
    assign code_wr_en = (state_reg == ST_EXEC) && (mode_reg == MODE_LOAD) && last_reg &&
                        out_free && !table_full && !ovf_eff;
    assign code_rd_en = (state_reg == ST_EXEC) && (mode_reg == MODE_QUERY) && last_reg;

    pcmt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_KW_LEN)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (load_pos_reg[POS_W-1:0]),
        .wr_data (row_wr_data),
        .rd_en   (row_rd_en),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    pcmt_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (code_wr_en),
        .wr_addr (entry_count_reg[IDX_W-1:0]),
        .wr_data (code_reg),
        .rd_en   (code_rd_en),
        .rd_addr (hit.idx),
        .rd_data (code_rd_data)
    );

    pcmt_match u_match (
        .row        (row_rd_data),
        .char_val   (char_reg),
        .qpos       (query_pos_reg),
        .count      (entry_count_reg),
        .lens       (len_reg),
        .alive      (alive_reg),
        .alive_next (match_alive),
        .hit        (hit)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept, then read the row (and write it back for a load), then answer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        load_pos_next    = load_pos_reg;
        load_ovf_next    = load_ovf_reg;
        query_pos_next   = query_pos_reg;
        alive_next       = alive_reg;
        len_next         = len_reg;
        hit_found_next   = hit_found_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_code_next    = out_code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (mode_reg == MODE_LOAD)
                begin
                    if (!last_reg)
                    begin
                        load_ovf_next = ovf_eff;
                        load_pos_next = lpos_inc;
                        state_next    = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_LOAD;
                        out_found_next = 1'b0;
                        out_code_next  = '0;
                        if (table_full)
                        begin
                            out_status_next = LOAD_FULL;
                        end
                        else if (ovf_eff)
                        begin
                            out_status_next = LOAD_TOO_LONG;
                        end
                        else
                        begin
                            out_status_next = LOAD_STORED;
                            len_next[entry_count_reg[IDX_W-1:0]] = LEN_W'(lpos_inc);
                            // an entry stored mid-query sits out that query
                            alive_next[entry_count_reg[IDX_W-1:0]] =
                                (query_pos_reg == '0);
                            entry_count_next = entry_count_reg + 1'b1;
                        end
                        load_pos_next = '0;
                        load_ovf_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    if (last_reg)
                    begin
                        hit_found_next = hit.found;
                        query_pos_next = '0;
                        alive_next     = '1;
                        state_next     = ST_CODE;
                    end
                    else
                    begin
                        alive_next     = match_alive;
                        query_pos_next = (query_pos_reg < LEN_W'(MAX_KW_LEN)) ?
                                         query_pos_reg + 1'b1 : query_pos_reg;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_CODE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_QUERY;
                    out_status_next = LOAD_STORED;
                    out_found_next  = hit_found_reg;
                    out_code_next   = hit_found_reg ? code_rd_data : '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            load_pos_reg    <= '0;
            load_ovf_reg    <= 1'b0;
            query_pos_reg   <= '0;
            alive_reg       <= '1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            load_pos_reg    <= load_pos_next;
            load_ovf_reg    <= load_ovf_next;
            query_pos_reg   <= query_pos_next;
            alive_reg       <= alive_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload: hold the accepted item, lengths, and the result fields.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= s_axis_tuser;
            last_reg <= s_axis_tlast;
            char_reg <= s_axis_tdata[CHAR_W-1:0];
            code_reg <= s_axis_tdata[CHAR_W +: CODE_W];
        end
        len_reg        <= len_next;
        hit_found_reg  <= hit_found_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_code_reg   <= out_code_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - CODE_W - 3)'(0), out_code_reg,
                            out_found_reg, out_status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past table size");

    a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        load_ovf_reg |-> (load_pos_reg > LPOS_W'(MAX_KW_LEN)))
        else $error("overflow flag without a long keyword");

    a_query_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE) |-> ((query_pos_reg == '0) && (&alive_reg)))
        else $error("query state not cleared after final character");

    a_answer_origin: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && (out_kind_reg == KIND_QUERY)) |->
            $past(state_reg == ST_CODE))
        else $error("query answer without code lookup");
`endif

endmodule

### tb/testbench.sv
// ============================================================================
// testbench: self-checking bench for the prefix command match table
// Streams keyword loads and queries into the table, predicts every status and
// answer with an internal model or a scripted reply, and compares each result
// transfer field by field. A short scripted opening is followed by about two
// thousand random characters under changing back-pressure.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import pcmt_pkg::*;

    // one result as the table reports it
    typedef struct {
        logic              kind;
        logic [1:0]        status;
        logic              found;
        logic [CODE_W-1:0] code;
    } reply_t;

    // one character as it goes onto the input stream
    typedef struct {
        logic              mode;
        char_t             ch;
        logic              lst;
        logic [CODE_W-1:0] code;
        bit                pinned;    // use the reply below instead of the model
        reply_t            want;
    } stim_t;

    // one line of the scripted opening: reps copies of ch, last on the final one
    typedef struct {
        logic              mode;
        char_t             ch;
        int                reps;
        logic              lst;
        logic [CODE_W-1:0] code;
        bit                pinned;
        logic [1:0]        status;
        logic              found;
        logic [CODE_W-1:0] code_out;
    } script_row_t;

    localparam int SCRIPT_ROWS = 12;
    localparam int POOL_SIZE   = 32;
    localparam int STR_MAX     = 24;
    localparam int RANDOM_ITEMS = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;    // [7:0] char_in, [23:8] code_in
    logic                   s_axis_tlast;    // last
    logic                   s_axis_tuser;    // mode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [1:0] status, [2] found, [18:3] code_out
    logic                   m_axis_tuser;    // result_kind

    prefix_command_match_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model: own copy of the keyword store and the two string cursors
    // ------------------------------------------------------------------------
    char_t                 kw_char [MAX_ENTRIES][MAX_KW_LEN];
    len_t                  kw_len  [MAX_ENTRIES];
    logic [CODE_W-1:0]     kw_code [MAX_ENTRIES];
    logic [CNT_W-1:0]      n_entries = '0;
    logic [LPOS_W-1:0]     ld_pos    = '0;
    logic                  ld_ovf    = 1'b0;
    logic [LEN_W-1:0]      q_pos     = '0;
    logic [MAX_ENTRIES-1:0] alive    = '1;

    // Advance the model by one accepted character; return 1 when it yields a result.
    function automatic bit match_table_step(input logic mode, input char_t ch,
                                            input logic lst,
                                            input logic [CODE_W-1:0] code,
                                            output reply_t r);
        r = '{kind: KIND_LOAD, status: LOAD_STORED, found: 1'b0, code: '0};
        if (mode == MODE_LOAD)
        begin
            // a full table stores nothing, but an overlong keyword still flags
            if (n_entries < MAX_ENTRIES)
            begin
                if (ld_pos < MAX_KW_LEN)
                    kw_char[n_entries][ld_pos] = ch;
                else
                    ld_ovf = 1'b1;
            end
            else if (ld_pos >= MAX_KW_LEN)
                ld_ovf = 1'b1;
            if (ld_pos <= MAX_KW_LEN)
                ld_pos = ld_pos + 1'b1;
            if (!lst)
                return 1'b0;
            if (n_entries >= MAX_ENTRIES)
                r.status = LOAD_FULL;
            else if (ld_ovf)
                r.status = LOAD_TOO_LONG;
            else
            begin
                kw_len[n_entries]  = len_t'(ld_pos);
                kw_code[n_entries] = code;
                // an entry stored mid-query sits out that query
                alive[n_entries] = (q_pos == 0);
                n_entries = n_entries + 1'b1;
            end
            ld_pos = '0;
            ld_ovf = 1'b0;
            return 1'b1;
        end

        r.kind = KIND_QUERY;
        if (q_pos < MAX_KW_LEN)
        begin
            for (int i = 0; i < int'(n_entries); i++)
                if (q_pos < kw_len[i] && kw_char[i][q_pos] != ch)
                    alive[i] = 1'b0;
            q_pos = q_pos + 1'b1;
        end
        if (!lst)
            return 1'b0;
        for (int i = 0; i < int'(n_entries); i++)
        begin
            if (alive[i] && kw_len[i] <= q_pos)
            begin
                r.found = 1'b1;
                r.code  = kw_code[i];
                break;
            end
        end
        q_pos = '0;
        alive = '1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus store and keyword pool for building matching queries
    // ------------------------------------------------------------------------
    stim_t       char_stream [$];
    reply_t      replies_due [$];
    script_row_t script [SCRIPT_ROWS];
    stim_t       offered;

    char_t       kw_pool     [POOL_SIZE][STR_MAX];
    int          kw_pool_len [POOL_SIZE];
    int          n_pool  = 0;
    int          n_loads = 0;

    int unsigned src_idle_pct = 14;
    int unsigned snk_idle_pct = 86;
    bit          hold_armed   = 1'b0;

    // checker tallies
    int unsigned n_errors    = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_stored    = 0;
    int unsigned n_full      = 0;
    int unsigned n_too_long  = 0;
    int unsigned n_queries   = 0;
    int unsigned n_hits      = 0;

    // mostly a three-letter alphabet so prefixes collide; now and then any nonzero byte
    function automatic char_t rand_char();
        if ($urandom_range(99) < 75)
            return char_t'(8'h61 + $urandom_range(2));
        return char_t'($urandom_range(255, 1));
    endfunction

    task automatic push_char(input logic mode, input char_t ch, input logic lst);
        stim_t it;
        it.mode   = mode;
        it.ch     = ch;
        it.lst    = lst;
        it.code   = CODE_W'($urandom_range(16'hFFFF));
        it.pinned = 1'b0;
        it.want   = '{kind: KIND_LOAD, status: LOAD_STORED, found: 1'b0, code: '0};
        char_stream.push_back(it);
    endtask

    task automatic push_query(input bit nest);
        char_t s [STR_MAX];
        int    len;
        int    pick;
        int    base_len;
        int    cut;
        base_len = 0;
        pick = $urandom_range(99);
        // start from a known keyword most of the time so that hits are common
        if (n_pool > 0 && pick < 70)
        begin
            int b;
            b = $urandom_range(n_pool - 1);
            base_len = kw_pool_len[b];
            for (int i = 0; i < base_len; i++)
                s[i] = kw_pool[b][i];
        end
        pick = $urandom_range(99);
        if (pick < 10)
            len = $urandom_range(STR_MAX, MAX_KW_LEN + 1);          // runs past the compare window
        else if (pick < 22 && base_len > 1)
            len = base_len - 1;                                      // shorter than the keyword
        else if (base_len > 0)
            len = base_len + $urandom_range(3);
        else
            len = $urandom_range(6, 1);
        if (len > STR_MAX)
            len = STR_MAX;
        for (int i = base_len; i < len; i++)
            s[i] = rand_char();
        cut = (nest && len >= 2 && $urandom_range(99) < 15) ? $urandom_range(len - 1, 1) : 0;
        for (int i = 0; i < len; i++)
        begin
            if (cut != 0 && i == cut)
                push_load(1'b0);
            push_char(MODE_QUERY, s[i], i == len - 1);
        end
    endtask

    task automatic push_load(input bit nest);
        char_t s [STR_MAX];
        int    len;
        int    pick;
        int    cut;
        int    slot;
        pick = $urandom_range(99);
        if (pick < 60)
            len = $urandom_range(4, 1);
        else if (pick < 75)
            len = $urandom_range(MAX_KW_LEN - 1, 5);
        else if (pick < 88)
            len = MAX_KW_LEN;
        else
            len = $urandom_range(MAX_KW_LEN + 4, MAX_KW_LEN + 1);
        for (int i = 0; i < len; i++)
            s[i] = rand_char();
        if (len <= MAX_KW_LEN)
        begin
            slot = (n_pool < POOL_SIZE) ? n_pool : $urandom_range(POOL_SIZE - 1);
            if (n_pool < POOL_SIZE)
                n_pool++;
            kw_pool_len[slot] = len;
            for (int i = 0; i < len; i++)
                kw_pool[slot][i] = s[i];
        end
        cut = (nest && len >= 2 && $urandom_range(99) < 10) ? $urandom_range(len - 1, 1) : 0;
        for (int i = 0; i < len; i++)
        begin
            if (cut != 0 && i == cut)
                push_query(1'b0);
            push_char(MODE_LOAD, s[i], i == len - 1);
        end
        n_loads++;
    endtask

    // Offer one character; hold it until the transfer happens.
    task automatic send_char(input stim_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.code, it.ch};
        s_axis_tlast  <= it.lst;
        s_axis_tuser  <= it.mode;
        offered       <= it;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // ------------------------------------------------------------------------
    // Input monitor: run the model on every accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            n_accepted++;
            if (match_table_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast,
                                 s_axis_tdata[23:8], r))
            begin
                // scripted rows carry their answer typed in; the model still advances
                if (offered.pinned)
                    r = offered.want;
                replies_due.push_back(r);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("unexpected result: kind %0b tdata %h", m_axis_tuser, m_axis_tdata);
                n_errors++;
            end
            else
            begin
                w = replies_due.pop_front();
                if (m_axis_tuser !== w.kind)
                begin
                    $error("result_kind: expected %0b, got %0b", w.kind, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[1:0] !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, m_axis_tdata[1:0]);
                    n_errors++;
                end
                if (m_axis_tdata[2] !== w.found)
                begin
                    $error("found: expected %0b, got %0b", w.found, m_axis_tdata[2]);
                    n_errors++;
                end
                if (m_axis_tdata[18:3] !== w.code)
                begin
                    $error("code_out: expected %h, got %h", w.code, m_axis_tdata[18:3]);
                    n_errors++;
                end
                if (w.kind == KIND_QUERY)
                begin
                    n_queries++;
                    if (w.found)
                        n_hits++;
                end
                else if (w.status == LOAD_STORED)
                    n_stored++;
                else if (w.status == LOAD_FULL)
                    n_full++;
                else
                    n_too_long++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off to back the table up
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: script, random stream, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        stim_t       it;
        int          total;
        int          n_script;
        int          guard;
        int unsigned leftover;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= MODE_LOAD;

        // mode, char, reps, last, code, pinned, status, found, code_out
        script = '{
            // query into an empty table finds nothing
            '{MODE_QUERY, 8'h41,  1, 1'b1, 16'h0000, 1'b1, LOAD_STORED,   1'b0, 16'h0000},
            // seventeen characters: one past the longest keyword
            '{MODE_LOAD,  8'h55, 16, 1'b0, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            '{MODE_LOAD,  8'hAA,  1, 1'b1, 16'h1234, 1'b1, LOAD_TOO_LONG, 1'b0, 16'h0000},
            // top character, top code
            '{MODE_LOAD,  8'hFF,  1, 1'b1, 16'hFFFF, 1'b1, LOAD_STORED,   1'b0, 16'h0000},
            // keyword ending in a zero character, code zero
            '{MODE_LOAD,  8'h01,  1, 1'b0, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            '{MODE_LOAD,  8'h00,  1, 1'b1, 16'h0000, 1'b1, LOAD_STORED,   1'b0, 16'h0000},
            // open a query, then store a keyword while it is in flight
            '{MODE_QUERY, 8'h01,  1, 1'b0, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            '{MODE_LOAD,  8'h01,  1, 1'b1, 16'h0001, 1'b1, LOAD_STORED,   1'b0, 16'h0000},
            // the new entry must sit out the open query
            '{MODE_QUERY, 8'h00,  1, 1'b1, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            // one-character query: the two-character keyword is too long to match
            '{MODE_QUERY, 8'h01,  1, 1'b1, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            // query longer than the keyword it starts with
            '{MODE_QUERY, 8'hFF,  2, 1'b1, 16'h0000, 1'b0, LOAD_STORED,   1'b0, 16'h0000},
            '{MODE_QUERY, 8'h02,  1, 1'b1, 16'h0000, 1'b1, LOAD_STORED,   1'b0, 16'h0000}
        };

        foreach (script[r])
        begin
            for (int k = 0; k < script[r].reps; k++)
            begin
                it.mode        = script[r].mode;
                it.ch          = script[r].ch;
                it.lst         = script[r].lst && (k == script[r].reps - 1);
                it.code        = script[r].code;
                it.pinned      = script[r].pinned && it.lst;
                it.want.kind   = (script[r].mode == MODE_QUERY) ? KIND_QUERY : KIND_LOAD;
                it.want.status = script[r].status;
                it.want.found  = script[r].found;
                it.want.code   = script[r].code_out;
                char_stream.push_back(it);
            end
        end
        n_script = char_stream.size();

        // loads are frequent for the first 28 keywords, then rare
        while (char_stream.size() < n_script + RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < ((n_loads < 28) ? 30 : 8))
                push_load(1'b1);
            else
                push_query(1'b1);
        end
        total = char_stream.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < total; k++)
        begin
            // swap who stalls at one third, stop stalling and choke the output at two
            if (k == total / 3)
            begin
                src_idle_pct = 86;
                snk_idle_pct = 14;
            end
            if (k == 2 * total / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_armed   = 1'b1;
            end
            send_char(char_stream[k]);
        end
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (replies_due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        // let any stray result surface
        repeat (16) @(posedge clk);

        leftover = replies_due.size();
        if (leftover != 0)
            $error("%0d expected results never arrived", leftover);

        $display("%0d characters sent; %0d keywords stored, %0d refused full, %0d too long",
                 n_accepted, n_stored, n_full, n_too_long);
        $display("%0d queries answered, %0d of them with a matching keyword",
                 n_queries, n_hits);
        if (n_errors == 0 && leftover == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: end the run as failed if the main sequence never finishes.
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
